// ===== design/mbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types and constants of the multi-button debouncer.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int PIN_COUNT = 8;
  localparam int TIME_W    = 32;
  localparam int TIMER_W   = 16;
  localparam int HIST_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [HIST_W-1:0] HISTORY_RESET = 32'hFFFF_FFFF;
  localparam logic [TIMER_W-1:0] REPEAT_RESET = 16'd33;

  // operation codes
  localparam logic OP_POLL   = 1'b0;
  localparam logic OP_REPEAT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED_MASK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TICKS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_MASK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 3'd4;

  typedef struct packed {
    logic [PIN_COUNT-1:0] enabled_mask;
    logic [TIMER_W-1:0]   min_ticks;
    logic [HIST_W-1:0]    glitch_mask;
    logic [TIMER_W-1:0]   lockout_ticks;
    logic [TIMER_W-1:0]   repeat_interval;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic released;
  } lane_evt_t;

endpackage

// ===== design/mbd_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_cfg
// Configuration register file, written through the cfg channel.
// ----------------------------------------------------------------------------
module mbd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [mbd_pkg::CFG_DAT_W-1:0]   wr_data,
  output mbd_pkg::cfg_t                   cfg
);

  mbd_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        mbd_pkg::REG_ENABLED_MASK:
          cfg_nxt.enabled_mask = wr_data[mbd_pkg::PIN_COUNT-1:0];
        mbd_pkg::REG_MIN_TICKS:
          cfg_nxt.min_ticks = wr_data[mbd_pkg::TIMER_W-1:0];
        mbd_pkg::REG_GLITCH_MASK:
          cfg_nxt.glitch_mask = wr_data[mbd_pkg::HIST_W-1:0];
        mbd_pkg::REG_LOCKOUT_TICKS:
          cfg_nxt.lockout_ticks = wr_data[mbd_pkg::TIMER_W-1:0];
        mbd_pkg::REG_REPEAT_INTERVAL:
          cfg_nxt.repeat_interval = wr_data[mbd_pkg::TIMER_W-1:0];
        default: begin
          // unmapped index, write ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled_mask    <= '1;
      cfg_r.min_ticks       <= 16'd1;
      cfg_r.glitch_mask     <= 32'd7;
      cfg_r.lockout_ticks   <= 16'd15;
      cfg_r.repeat_interval <= mbd_pkg::REPEAT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/mbd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_lane
// One button: lockout countdown, level history and stable level decision.
// ----------------------------------------------------------------------------
module mbd_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          poll_fire,
  input  logic [mbd_pkg::TIME_W-1:0]    ticks,
  input  logic                          pin,
  input  logic                          enabled,
  input  logic [mbd_pkg::HIST_W-1:0]    glitch_mask,
  input  logic [mbd_pkg::TIMER_W-1:0]   lockout_ticks,
  input  logic                          stable_level,
  output mbd_pkg::lane_evt_t            evt
);

  localparam int PAD_W = mbd_pkg::TIME_W - mbd_pkg::TIMER_W;

  logic [mbd_pkg::HIST_W-1:0]  hist_r, hist_nxt, hist_shift, sel;
  logic [mbd_pkg::TIMER_W-1:0] timer_r, timer_nxt, timer_dn;
  logic                        sample, lvl_lo, lvl_hi, new_level, change;

  always_comb begin
    // countdown by the elapsed time, saturating at zero
    if (timer_r == '0) begin
      timer_dn = '0;
    end else if (ticks < {{PAD_W{1'b0}}, timer_r}) begin
      timer_dn = timer_r - ticks[mbd_pkg::TIMER_W-1:0];
    end else begin
      timer_dn = '0;
    end

    sample     = enabled && (timer_dn == '0);
    hist_shift = {hist_r[mbd_pkg::HIST_W-2:0], pin};
    sel        = hist_shift & glitch_mask;
    // an empty glitch mask reads as all low
    lvl_lo     = (sel == '0);
    lvl_hi     = !lvl_lo && (sel == glitch_mask);
    new_level  = !lvl_lo;
    change     = poll_fire && sample && (lvl_lo || lvl_hi) && (new_level != stable_level);

    hist_nxt  = hist_r;
    timer_nxt = timer_r;
    if (poll_fire && enabled) begin
      timer_nxt = timer_dn;
      if (sample) begin
        hist_nxt = hist_shift;
      end
      if (change) begin
        timer_nxt = lockout_ticks;
      end
    end

    evt.pressed  = change && !new_level;
    evt.released = change && new_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= mbd_pkg::HISTORY_RESET;
      timer_r <= '0;
    end else begin
      hist_r  <= hist_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

// ===== design/multi_button_debouncer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_button_debouncer
// Debounces up to eight buttons with lockout, combo and repeat reporting.
// ----------------------------------------------------------------------------
// an accepted input is loaded into the input register, and its result into the result
//   register once the result register is free; one item per cycle sustained, held
//   only by out_stall
// all per-button work is one parallel pass of the lanes between the registers
// reset (rst_n low, synchronous): histories all ones, timers zero, no button
//   held, poll and repeat times zero, registers at their documented defaults
module multi_button_debouncer #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [mbd_pkg::TIME_W-1:0]      in_now_ms,
  input  logic [mbd_pkg::PIN_COUNT-1:0]   in_pin_levels,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_poll_done,
  output logic [mbd_pkg::PIN_COUNT-1:0]   out_pressed_mask,
  output logic [mbd_pkg::PIN_COUNT-1:0]   out_released_mask,
  output logic [mbd_pkg::PIN_COUNT-1:0]   out_combo_mask,
  output logic [mbd_pkg::PIN_COUNT-1:0]   out_held_mask,
  output logic [mbd_pkg::PIN_COUNT-1:0]   out_repeat_mask,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbd_pkg::CFG_DAT_W-1:0]   cfg_data
);

  localparam int NP    = mbd_pkg::PIN_COUNT;
  localparam int LANES = (NUM_BUTTONS < NP) ? NUM_BUTTONS : NP;
  localparam int PAD_W = mbd_pkg::TIME_W - mbd_pkg::TIMER_W;

  function automatic logic [NP-1:0] smear_down(input logic [NP-1:0] x);
    logic [NP-1:0] y;
    y = x | (x >> 1);
    y = y | (y >> 2);
    y = y | (y >> 4);
    return y;
  endfunction

  mbd_pkg::cfg_t cfg;

  // input register
  logic                         s1_valid_r, s1_valid_nxt;
  logic                         op_r;
  logic [mbd_pkg::TIME_W-1:0]   now_r;
  logic [NP-1:0]                pins_r;

  // block state
  logic [NP-1:0]                stable_r, stable_nxt;
  logic [NP-1:0]                accum_r, accum_nxt;
  logic [mbd_pkg::TIME_W-1:0]   last_poll_r, last_poll_nxt;
  logic [mbd_pkg::TIME_W-1:0]   last_rep_r, last_rep_nxt;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic                         done_r;
  logic [NP-1:0]                pressed_r, released_r, combo_r, held_r, rep_r;

  logic                         in_take, out_free, fire, poll_ok, poll_fire, rep_ok;
  logic [mbd_pkg::TIME_W-1:0]   ticks, rep_gap;
  logic [NP-1:0]                press_v, release_v, held0, combo_v;
  logic                         combo_evt;

  mbd_pkg::lane_evt_t           evt [LANES];

  assign cfg_ready = 1'b1;

  mbd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign ticks     = now_r - last_poll_r;
  assign poll_ok   = (op_r == mbd_pkg::OP_POLL) && (ticks >= {{PAD_W{1'b0}}, cfg.min_ticks});
  assign poll_fire = fire && poll_ok;
  assign rep_gap   = now_r - last_rep_r;
  assign rep_ok    = (op_r == mbd_pkg::OP_REPEAT)
                  && (rep_gap >= {{PAD_W{1'b0}}, cfg.repeat_interval});

  genvar gi;
  generate
    for (gi = 0; gi < NP; gi++) begin : g_btn
      if (gi < LANES) begin : g_lane
        mbd_lane u_lane (
          .clk           (clk),
          .rst_n         (rst_n),
          .poll_fire     (poll_fire),
          .ticks         (ticks),
          .pin           (pins_r[gi]),
          .enabled       (cfg.enabled_mask[gi]),
          .glitch_mask   (cfg.glitch_mask),
          .lockout_ticks (cfg.lockout_ticks),
          .stable_level  (stable_r[gi]),
          .evt           (evt[gi])
        );
        assign press_v[gi]   = evt[gi].pressed;
        assign release_v[gi] = evt[gi].released;
      end else begin : g_none
        assign press_v[gi]   = 1'b0;
        assign release_v[gi] = 1'b0;
      end
    end
  endgenerate

  // index order: the combo fires when the highest held button releases with
  // every held button released and no press at or below it
  assign held0     = ~stable_r;
  assign combo_evt = poll_fire && (held0 != '0) && ((held0 & ~release_v) == '0)
                  && ((press_v & smear_down(held0)) == '0);
  assign combo_v   = combo_evt ? accum_r : '0;

  always_comb begin
    stable_nxt    = (stable_r & ~press_v) | release_v;
    accum_nxt     = accum_r;
    last_poll_nxt = last_poll_r;
    last_rep_nxt  = last_rep_r;
    if (poll_fire) begin
      last_poll_nxt = now_r;
      accum_nxt     = combo_evt ? press_v : (accum_r | press_v);
    end
    if (fire && rep_ok) begin
      last_rep_nxt = now_r;
    end

    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      stable_r    <= '1;
      accum_r     <= '0;
      last_poll_r <= '0;
      last_rep_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      stable_r    <= stable_nxt;
      accum_r     <= accum_nxt;
      last_poll_r <= last_poll_nxt;
      last_rep_r  <= last_rep_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_operation;
      now_r  <= in_now_ms;
      pins_r <= in_pin_levels;
    end
    if (fire) begin
      done_r     <= poll_ok;
      pressed_r  <= press_v;
      released_r <= release_v;
      combo_r    <= combo_v;
      held_r     <= ~stable_nxt;
      rep_r      <= rep_ok ? held0 : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_poll_done     = done_r;
  assign out_pressed_mask  = pressed_r;
  assign out_released_mask = released_r;
  assign out_combo_mask    = combo_r;
  assign out_held_mask     = held_r;
  assign out_repeat_mask   = rep_r;

  a_skipped_poll_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_poll_done |->
      out_pressed_mask == '0 && out_released_mask == '0 && out_combo_mask == '0)
    else $error("result without a processed poll reports changes");

  a_press_release_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pressed_mask & out_released_mask) == '0)
    else $error("button both pressed and released in one poll");

  a_pressed_is_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pressed_mask & ~out_held_mask) == '0 &&
                  (out_released_mask & out_held_mask) == '0)
    else $error("change masks disagree with held mask");

  a_repeat_only_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_repeat_mask != '0 |->
      !out_poll_done && (out_repeat_mask & ~out_held_mask) == '0)
    else $error("repeat mask outside held buttons or on a poll");

  a_state_still_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(stable_r) && $stable(accum_r) && $stable(last_poll_r))
    else $error("debounce state moved without an item");

endmodule
